### rtl/core/segmentation_energy_eval_defines.svh
// ----------------------------------------------------------------------------
// Segmentation energy evaluator: assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENTATION_ENERGY_EVAL_DEFINES_SVH
`define SEGMENTATION_ENERGY_EVAL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SEGE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define SEGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle property failed");

`endif

### rtl/core/sege_pkg.sv
// ----------------------------------------------------------------------------
// sege_pkg
// Constants, register indexes, configuration struct and term tables.
// ----------------------------------------------------------------------------
package sege_pkg;

	localparam int unsigned MAX_WIDTH_DEF     = 4096;
	localparam int unsigned FRACTION_BITS_DEF = 8;
	localparam int unsigned ENERGY_BITS_DEF   = 48;

	localparam int unsigned WIDTH_REG_W = 13;
	localparam int unsigned ENTRY_W     = 12;

	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HIGH_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_LOW_THRESHOLD  = 2'd2;
	localparam logic [1:0] REG_PENALTY        = 2'd3;

	localparam logic [12:0] RST_IMAGE_WIDTH    = 13'd640;
	localparam logic [7:0]  RST_HIGH_THRESHOLD = 8'd80;
	localparam logic [7:0]  RST_LOW_THRESHOLD  = 8'd50;
	localparam logic [15:0] RST_PENALTY        = 16'd2000;

	// exp(-1/1800) in Q31.
	localparam longint unsigned E31 = 64'd2146290933;

	typedef struct packed {
		logic [7:0]  high;
		logic [7:0]  low;
		logic [15:0] pen;
	} sege_cfg_t;

	typedef logic [31:0] pair_tab_t [256];
	typedef logic [31:0] local_tab_t [5];

	function automatic longint unsigned mul_q31(input longint unsigned a,
			input longint unsigned b);
		return (a * b + 64'd1073741824) >> 31;
	endfunction

	// 5*exp(-d*d/1800) for d = 0..255, rounded to f fraction bits.
	function automatic pair_tab_t pair_table(input int unsigned f);
		pair_tab_t tab;
		longint unsigned res;
		longint unsigned base;
		logic [15:0] n;
		for (int d = 0; d < 256; d++) begin
			res = 64'd1 << 31;
			base = E31;
			n = 16'(d * d);
			for (int b = 0; b < 16; b++) begin
				if (n[b]) begin
					res = mul_q31(res, base);
				end
				base = mul_q31(base, base);
			end
			tab[d] = 32'((64'd5 * res + (64'd1 << (30 - f))) >> (31 - f));
		end
		return tab;
	endfunction

	// 10*ln(1+n) for n = 0..4, rounded to f fraction bits.
	function automatic local_tab_t local_table(input int unsigned f);
		local_tab_t tab;
		longint unsigned q20 [5];
		q20[0] = 64'd0;
		q20[1] = 64'd7268175;
		q20[2] = 64'd11519785;
		q20[3] = 64'd14536350;
		q20[4] = 64'd16876180;
		for (int k = 0; k < 5; k++) begin
			tab[k] = 32'((q20[k] + (64'd1 << (19 - f))) >> (20 - f));
		end
		return tab;
	endfunction

endpackage

### rtl/core/sege_queue.sv
// ----------------------------------------------------------------------------
// sege_queue
// Small first-in first-out queue between the pixel front and the adder.
// ----------------------------------------------------------------------------
module sege_queue #(
	parameter int unsigned W         = 27,
	parameter int unsigned DEPTH_LOG = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         restart,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int unsigned DEPTH = 1 << DEPTH_LOG;

	logic [W-1:0]         slot_q [DEPTH];
	logic [DEPTH_LOG-1:0] wp_q;
	logic [DEPTH_LOG-1:0] rp_q;
	logic [DEPTH_LOG:0]   cnt_q;

	assign full  = (cnt_q == (DEPTH_LOG+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (restart) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/sege_front.sv
// ----------------------------------------------------------------------------
// sege_front
// Accepts pixels, keeps the line store and neighbour state, forms each
// pixel's energy contribution and sweeps the line store at frame end.
// ----------------------------------------------------------------------------
`include "segmentation_energy_eval_defines.svh"

module sege_front #(
	parameter int unsigned MAX_WIDTH     = sege_pkg::MAX_WIDTH_DEF,
	parameter int unsigned FRACTION_BITS = sege_pkg::FRACTION_BITS_DEF,
	parameter int unsigned CW            = $clog2(MAX_WIDTH),
	parameter int unsigned VAL_W         = FRACTION_BITS + 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic [CW-1:0]       wlast,
	input  sege_pkg::sege_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          pixel_intensity,
	input  logic                pixel_label,
	input  logic                end_of_frame,
	output logic                q_push,
	output logic [VAL_W:0]      q_wdata,
	input  logic                q_full
);

	localparam int unsigned PAIR_W = FRACTION_BITS + 3;
	localparam int unsigned LT_W   = FRACTION_BITS + 16;
	localparam int unsigned EW     = sege_pkg::ENTRY_W;

	localparam sege_pkg::pair_tab_t  PAIR_TAB = sege_pkg::pair_table(FRACTION_BITS);
	localparam sege_pkg::local_tab_t LOC_TAB  = sege_pkg::local_table(FRACTION_BITS);

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DRD   = 2'd1;
	localparam logic [1:0] ST_DWAIT = 2'd2;

	function automatic logic [LT_W-1:0] lt_term(input logic [7:0] i, input logic l,
			input logic [2:0] n, input sege_pkg::sege_cfg_t c);
		logic [2:0] nn;
		nn = (n > 3'd4) ? 3'd4 : n;
		if ((i > c.high && !l) || (i < c.low && l)) begin
			return LT_W'(c.pen) << FRACTION_BITS;
		end
		return LT_W'(LOC_TAB[nn]);
	endfunction

	function automatic logic [VAL_W-1:0] pair_term(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return VAL_W'({PAIR_TAB[d][PAIR_W-1:0], 1'b0});
	endfunction

	logic [EW-1:0] line_mem [MAX_WIDTH];
	logic [EW-1:0] rd_q;

	logic [1:0]    state_q;
	logic [CW-1:0] col_q;
	logic          first_q;
	logic          s1_valid_q;
	logic [7:0]    x_s1;
	logic          lab_s1;
	logic          eof_s1;
	logic [CW-1:0] col_s1;
	logic          first_s1;
	logic [7:0]    li_q;
	logic          ll_q;
	logic [2:0]    lc_q;
	logic          pend_valid_q;
	logic [EW-1:0] pend_q;
	logic [CW-1:0] dcnt_q;
	logic [CW-1:0] dr_col_q;
	logic [CW-1:0] dr_last_q;

	logic          accept;
	logic          s1_fire;
	logic          rd_en;
	logic [CW-1:0] rd_addr;
	logic          mem_we;
	logic [CW-1:0] mem_waddr;
	logic [EW-1:0] mem_wdata;
	logic [EW-1:0] above;
	logic [7:0]    ai;
	logic          al;
	logic [2:0]    ac;
	logic          same_a;
	logic          same_l;
	logic [2:0]    cur;
	logic [2:0]    lc_new;
	logic          col_nz;
	logic [VAL_W-1:0] pix_val;
	logic [VAL_W-1:0] drn_val;
	logic          drn_last;
	logic          drn_skip;

	assign in_stall = !(state_q == ST_RUN && (!s1_valid_q || (!eof_s1 && !q_full)));
	assign accept   = in_valid && !in_stall;
	assign s1_fire  = s1_valid_q && !q_full;
	assign col_nz   = (col_s1 != '0);

	always_comb begin
		above  = (pend_valid_q && col_s1 == wlast) ? pend_q : rd_q;
		ai     = above[EW-1:4];
		al     = above[3];
		ac     = above[2:0];
		same_a = !first_s1 && (al == lab_s1);
		same_l = col_nz && (ll_q == lab_s1);
		cur    = 3'(same_a) + 3'(same_l);
		lc_new = lc_q + 3'(same_l);
		pix_val = '0;
		if (!first_s1) begin
			pix_val = pix_val + pair_term(x_s1, ai)
				+ VAL_W'(lt_term(ai, al, ac + 3'(same_a), cfg));
		end
		if (col_nz) begin
			pix_val = pix_val + pair_term(x_s1, li_q);
		end
		if (eof_s1) begin
			pix_val = pix_val + VAL_W'(lt_term(x_s1, lab_s1, cur, cfg));
			if (col_nz) begin
				pix_val = pix_val + VAL_W'(lt_term(li_q, ll_q, lc_new, cfg));
			end
		end
	end

	// The entries at and just left of the last pixel were counted with it.
	always_comb begin
		drn_skip = (dcnt_q == dr_col_q) || (dr_col_q != '0 && dcnt_q == dr_col_q - 1'b1);
		drn_last = (dcnt_q == dr_last_q);
		drn_val  = drn_skip ? '0 : VAL_W'(lt_term(rd_q[EW-1:4], rd_q[3], rd_q[2:0], cfg));
	end

	always_comb begin
		mem_we    = s1_fire && (col_nz || pend_valid_q);
		mem_waddr = col_nz ? (col_s1 - 1'b1) : wlast;
		mem_wdata = col_nz ? {li_q, ll_q, lc_new} : pend_q;
		rd_en     = accept || (state_q == ST_DRD);
		rd_addr   = (state_q == ST_DRD) ? dcnt_q : col_q;
		if (state_q == ST_DWAIT) begin
			q_push  = !q_full;
			q_wdata = {drn_last, drn_val};
		end else begin
			q_push  = s1_fire;
			q_wdata = {1'b0, pix_val};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			if (mem_we && mem_waddr == rd_addr) begin
				rd_q <= mem_wdata;
			end else begin
				rd_q <= line_mem[rd_addr];
			end
		end
		if (accept) begin
			x_s1     <= pixel_intensity;
			lab_s1   <= pixel_label;
			eof_s1   <= end_of_frame;
			col_s1   <= col_q;
			first_s1 <= first_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			col_q        <= '0;
			first_q      <= 1'b1;
			s1_valid_q   <= 1'b0;
			li_q         <= '0;
			ll_q         <= 1'b0;
			lc_q         <= '0;
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			dcnt_q       <= '0;
			dr_col_q     <= '0;
			dr_last_q    <= '0;
		end else if (restart) begin
			state_q      <= ST_RUN;
			col_q        <= '0;
			first_q      <= 1'b1;
			s1_valid_q   <= 1'b0;
			li_q         <= '0;
			ll_q         <= 1'b0;
			lc_q         <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (end_of_frame) begin
					col_q   <= '0;
					first_q <= 1'b1;
				end else if (col_q == wlast) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_fire) begin
				if (eof_s1) begin
					li_q         <= '0;
					ll_q         <= 1'b0;
					lc_q         <= '0;
					pend_valid_q <= 1'b0;
					dcnt_q       <= '0;
					dr_col_q     <= col_s1;
					dr_last_q    <= first_s1 ? col_s1 : wlast;
					state_q      <= ST_DRD;
				end else if (col_s1 == wlast) begin
					pend_valid_q <= 1'b1;
					pend_q       <= {x_s1, lab_s1, cur};
				end else begin
					li_q <= x_s1;
					ll_q <= lab_s1;
					lc_q <= cur;
					if (!col_nz) begin
						pend_valid_q <= 1'b0;
					end
				end
			end

			case (state_q)
				ST_DRD: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (!q_full) begin
						if (drn_last) begin
							state_q <= ST_RUN;
						end else begin
							dcnt_q  <= dcnt_q + 1'b1;
							state_q <= ST_DRD;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	`SEGE_ASSERT_SAME(a_no_accept_in_drain, clk, arst_n, state_q != ST_RUN, in_stall)
	`SEGE_ASSERT_NEXT(a_eof_starts_drain, clk, arst_n, s1_fire && eof_s1, state_q == ST_DRD)
	`SEGE_ASSERT_SAME(a_push_not_full, clk, arst_n, q_push, !q_full)

endmodule

### rtl/core/sege_back.sv
// ----------------------------------------------------------------------------
// sege_back
// Saturating energy accumulator and registered result stage.
// ----------------------------------------------------------------------------
`include "segmentation_energy_eval_defines.svh"

module sege_back #(
	parameter int unsigned VAL_W       = 26,
	parameter int unsigned ENERGY_BITS = sege_pkg::ENERGY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   restart,
	input  logic                   q_empty,
	input  logic [VAL_W:0]         q_rdata,
	output logic                   q_pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ENERGY_BITS-1:0] energy_total,
	output logic                   energy_saturated
);

	localparam int unsigned SUM_W = ((ENERGY_BITS > VAL_W) ? ENERGY_BITS : VAL_W) + 1;
	localparam logic [ENERGY_BITS-1:0] E_MAX = '1;

	logic [ENERGY_BITS-1:0] acc_q;
	logic                   out_valid_q;
	logic [ENERGY_BITS-1:0] total_q;
	logic                   sat_q;

	logic                   last;
	logic [SUM_W-1:0]       sum;
	logic [ENERGY_BITS-1:0] nacc;

	assign last  = q_rdata[VAL_W];
	assign q_pop = !q_empty && (!last || !out_valid_q || !out_stall);
	assign sum   = SUM_W'(acc_q) + SUM_W'(q_rdata[VAL_W-1:0]);
	assign nacc  = (sum > SUM_W'(E_MAX)) ? E_MAX : sum[ENERGY_BITS-1:0];

	assign out_valid        = out_valid_q;
	assign energy_total     = total_q;
	assign energy_saturated = sat_q;

	always_ff @(posedge clk) begin
		if (q_pop && last) begin
			total_q <= nacc;
			sat_q   <= (nacc == E_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (restart) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q <= last ? '0 : nacc;
			end
			if (q_pop && last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SEGE_ASSERT_NEXT(a_last_gives_result, clk, arst_n, q_pop && last, out_valid_q && acc_q == '0)

endmodule

### rtl/core/segmentation_energy_eval.sv
// ----------------------------------------------------------------------------
// segmentation_energy_eval
// Binary segmentation energy over a 4-neighbour pixel grid, one total per
// frame, with an APB-style register port.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake           Beat
//  pixel in  in_valid/in_stall   pixel_intensity, pixel_label, end_of_frame
//  energy    out_valid/out_stall energy_total, energy_saturated
//  config    psel/penable/pready paddr, pwdata, prdata
//
// A pixel beat is taken every cycle while the queue to the accumulator has
// room and no frame end is staged or being swept; each accepted pixel is worked in a stage
// register before its term is queued, so the sustained rate is one pixel per cycle.
// At frame end the front sweeps the line store, reading each column and then
// queueing its term, for up to image_width columns (clipped to the store size).
// The result is registered when the last queued term is taken and waits in its own
// register, so a stalled result holds back only the next frame's final term.
// Reset needs no clearing pass: the line store is read only where written.
// ----------------------------------------------------------------------------
module segmentation_energy_eval #(
	parameter int unsigned MAX_WIDTH     = sege_pkg::MAX_WIDTH_DEF,
	parameter int unsigned FRACTION_BITS = sege_pkg::FRACTION_BITS_DEF,
	parameter int unsigned ENERGY_BITS   = sege_pkg::ENERGY_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             pixel_intensity,
	input  logic                   pixel_label,
	input  logic                   end_of_frame,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [ENERGY_BITS-1:0] energy_total,
	output logic                   energy_saturated
);

	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned VAL_W = FRACTION_BITS + 18;

	// Register file. Writing the width restarts the frame in the front, the queue and the back.
	logic [sege_pkg::WIDTH_REG_W-1:0] width_q;
	sege_pkg::sege_cfg_t              cfg_q;
	logic                             wr;
	logic                             restart;
	logic [CW-1:0]                    wlast;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr && (paddr[3:2] == sege_pkg::REG_IMAGE_WIDTH);

	// A width of zero behaves as one column; anything over the store size is clipped.
	always_comb begin
		if (width_q == '0) begin
			wlast = '0;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wlast = CW'(MAX_WIDTH - 1);
		end else begin
			wlast = CW'(32'(width_q) - 32'd1);
		end
	end

	always_comb begin
		case (paddr[3:2])
			sege_pkg::REG_IMAGE_WIDTH:    prdata = 32'(width_q);
			sege_pkg::REG_HIGH_THRESHOLD: prdata = 32'(cfg_q.high);
			sege_pkg::REG_LOW_THRESHOLD:  prdata = 32'(cfg_q.low);
			sege_pkg::REG_PENALTY:        prdata = 32'(cfg_q.pen);
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= sege_pkg::RST_IMAGE_WIDTH;
			cfg_q.high <= sege_pkg::RST_HIGH_THRESHOLD;
			cfg_q.low  <= sege_pkg::RST_LOW_THRESHOLD;
			cfg_q.pen  <= sege_pkg::RST_PENALTY;
		end else if (wr) begin
			case (paddr[3:2])
				sege_pkg::REG_IMAGE_WIDTH:    width_q    <= pwdata[sege_pkg::WIDTH_REG_W-1:0];
				sege_pkg::REG_HIGH_THRESHOLD: cfg_q.high <= pwdata[7:0];
				sege_pkg::REG_LOW_THRESHOLD:  cfg_q.low  <= pwdata[7:0];
				sege_pkg::REG_PENALTY:        cfg_q.pen  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [VAL_W:0]   q_wdata;
	logic [VAL_W:0]   q_rdata;

	// Front: pixel acceptance, line store, neighbour terms and frame-end sweep.
	sege_front #(
		.MAX_WIDTH     (MAX_WIDTH),
		.FRACTION_BITS (FRACTION_BITS),
		.CW            (CW),
		.VAL_W         (VAL_W)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.restart         (restart),
		.wlast           (wlast),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel_intensity (pixel_intensity),
		.pixel_label     (pixel_label),
		.end_of_frame    (end_of_frame),
		.q_push          (q_push),
		.q_wdata         (q_wdata),
		.q_full          (q_full)
	);

	// Terms in flight between the front and the accumulator.
	sege_queue #(
		.W         (VAL_W + 1),
		.DEPTH_LOG (2)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.push    (q_push),
		.wdata   (q_wdata),
		.pop     (q_pop),
		.rdata   (q_rdata),
		.full    (q_full),
		.empty   (q_empty)
	);

	// Back: saturating sum and the result register.
	sege_back #(
		.VAL_W       (VAL_W),
		.ENERGY_BITS (ENERGY_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.restart          (restart),
		.q_empty          (q_empty),
		.q_rdata          (q_rdata),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.energy_total     (energy_total),
		.energy_saturated (energy_saturated)
	);

endmodule

### test/segmentation_energy_eval_tb.sv
// ----------------------------------------------------------------------------
// Segmentation energy evaluator testbench
// Drives raster pixel frames through the block under several register
// settings and idling patterns, and checks every frame energy total and saturation
// flag against a cycle-free 4-neighbour predictor in this file or a typed-in total.
// ----------------------------------------------------------------------------
module segmentation_energy_eval_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LINE_DEPTH   = 4096;
	localparam int unsigned FRAC         = 8;
	localparam longint unsigned E_MAX    = (64'd1 << 48) - 64'd1;
	localparam int unsigned WATCHDOG_MAX = 60000;
	localparam int unsigned ITEM_TARGET  = 1750;

	typedef struct {
		logic [47:0] total;
		logic        sat;
	} energy_beat_t;

	typedef struct {
		logic [7:0]  intensity;
		logic        label;
		logic        eof;
		bit          known;
		logic [47:0] total;
	} pixel_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  pixel_intensity = '0;
	logic        pixel_label = 1'b0;
	logic        end_of_frame = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [47:0] energy_total;
	logic        energy_saturated;

	segmentation_energy_eval dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_intensity(pixel_intensity), .pixel_label(pixel_label),
		.end_of_frame(end_of_frame),
		.out_valid(out_valid), .out_stall(out_stall),
		.energy_total(energy_total), .energy_saturated(energy_saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the register file, as the predictor sees it.
	logic [12:0] cfg_width = sege_pkg::RST_IMAGE_WIDTH;
	logic [7:0]  cfg_high  = sege_pkg::RST_HIGH_THRESHOLD;
	logic [7:0]  cfg_low   = sege_pkg::RST_LOW_THRESHOLD;
	logic [15:0] cfg_pen   = sege_pkg::RST_PENALTY;

	// Predictor state: the row above, the left pixel and the running sum.
	logic [7:0]  row_above_int [LINE_DEPTH];
	logic        row_above_lab [LINE_DEPTH];
	logic [2:0]  row_above_cnt [LINE_DEPTH];
	logic [7:0]  left_int;
	logic        left_lab;
	int unsigned left_cnt;
	int unsigned column;
	bit          in_first_row;
	longint unsigned energy_sum;

	longint unsigned pair_cost [256];
	longint unsigned same_cost [5];

	energy_beat_t pending_energy [$];
	int unsigned  mismatches = 0;
	int unsigned  idle_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  items_sent = 0;

	// The pair table is 5*exp(-d*d/1800): the base is a seven-term series in
	// Q62 rounded to Q31, then raised by square-and-multiply with each Q31
	// product rounded half up.
	function automatic longint unsigned q31_product(input longint unsigned a,
			input longint unsigned b);
		return (a * b + (64'd1 << 30)) >> 31;
	endfunction

	function automatic void build_cost_tables();
		longint unsigned term;
		longint unsigned series;
		longint unsigned base31;
		longint unsigned acc;
		longint unsigned sq;
		int unsigned n;
		longint unsigned ln_q20 [5];
		term = 64'd1 << 62;
		series = term;
		for (int k = 1; k <= 6; k++) begin
			term = term / (64'd1800 * k);
			if (k % 2 == 1) series = series - term;
			else series = series + term;
		end
		base31 = (series + (64'd1 << 30)) >> 31;
		for (int d = 0; d < 256; d++) begin
			acc = 64'd1 << 31;
			sq = base31;
			n = d * d;
			while (n != 0) begin
				if (n % 2 == 1) acc = q31_product(acc, sq);
				sq = q31_product(sq, sq);
				n = n / 2;
			end
			pair_cost[d] = (64'd5 * acc + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
		end
		ln_q20 = '{64'd0, 64'd7268175, 64'd11519785, 64'd14536350, 64'd16876180};
		for (int k = 0; k < 5; k++)
			same_cost[k] = (ln_q20[k] + (64'd1 << (19 - FRAC))) >> (20 - FRAC);
	endfunction

	function automatic void add_energy(input longint unsigned v);
		if (v > E_MAX - energy_sum) energy_sum = E_MAX;
		else energy_sum = energy_sum + v;
	endfunction

	// A contradicted label costs the whole penalty; otherwise the cost
	// rises with the number of like-labelled neighbours.
	function automatic longint unsigned label_cost(input logic [7:0] x,
			input logic lab, input int unsigned cnt);
		if ((x > cfg_high && lab == 1'b0) || (x < cfg_low && lab == 1'b1))
			return longint'(cfg_pen) << FRAC;
		return same_cost[cnt > 4 ? 4 : cnt];
	endfunction

	function automatic void add_pair(input logic [7:0] a, input logic [7:0] b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		add_energy(pair_cost[d]);
		add_energy(pair_cost[d]);
	endfunction

	function automatic void restart_frame();
		left_int = '0;
		left_lab = 1'b0;
		left_cnt = 0;
		column = 0;
		in_first_row = 1'b1;
		energy_sum = 0;
	endfunction

	function automatic void keep_above(input int unsigned c, input logic [7:0] x,
			input logic lab, input int unsigned cnt);
		row_above_int[c] = x;
		row_above_lab[c] = lab;
		row_above_cnt[c] = cnt[2:0];
	endfunction

	// Adds one pixel to the frame energy; returns 1 with the total when the
	// pixel closes the frame. A stored count still lacks its below neighbour,
	// which is added when the pixel under it arrives; at frame end the
	// leftover row is swept with no below neighbour.
	function automatic bit energy_of_pixel(input logic [7:0] x, input logic lab,
			input logic eof, output energy_beat_t beat);
		int unsigned w;
		int unsigned col;
		int unsigned cur;
		int unsigned acnt;
		cur = 0;
		w = (cfg_width == 0) ? 1 : (cfg_width > LINE_DEPTH ? LINE_DEPTH : cfg_width);
		col = (column >= w) ? w - 1 : column;
		if (!in_first_row) begin
			add_pair(x, row_above_int[col]);
			acnt = row_above_cnt[col];
			if (row_above_lab[col] == lab) begin
				cur++;
				acnt++;
			end
			add_energy(label_cost(row_above_int[col], row_above_lab[col], acnt));
		end
		if (col > 0) begin
			add_pair(x, left_int);
			if (left_lab == lab) begin
				cur++;
				left_cnt++;
			end
			keep_above(col - 1, left_int, left_lab, left_cnt);
		end
		if (eof) begin
			keep_above(col, x, lab, cur);
			for (int c = 0; c <= col; c++)
				add_energy(label_cost(row_above_int[c], row_above_lab[c], row_above_cnt[c]));
			if (!in_first_row)
				for (int c = col + 1; c < w; c++)
					add_energy(label_cost(row_above_int[c], row_above_lab[c],
						row_above_cnt[c]));
			beat.total = energy_sum[47:0];
			beat.sat = (energy_sum == E_MAX);
			restart_frame();
			return 1'b1;
		end
		if (col == w - 1) begin
			keep_above(col, x, lab, cur);
			column = 0;
			in_first_row = 1'b0;
		end else begin
			left_int = x;
			left_lab = lab;
			left_cnt = cur;
			column = col + 1;
		end
		return 1'b0;
	endfunction

	// Register write: setup cycle then access cycle; pready is always high,
	// so the write lands at the edge that ends the access cycle.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			sege_pkg::REG_IMAGE_WIDTH: begin
				cfg_width = value[12:0];
				restart_frame();
			end
			sege_pkg::REG_HIGH_THRESHOLD: cfg_high = value[7:0];
			sege_pkg::REG_LOW_THRESHOLD:  cfg_low = value[7:0];
			sege_pkg::REG_PENALTY:        cfg_pen = value[15:0];
			default: ;
		endcase
	endtask

	// Sends one pixel beat, with random sender gaps first. When the row
	// carries a typed-in total, that total is what the result must show.
	task automatic send_pixel(input logic [7:0] x, input logic lab, input logic eof,
			input bit known, input logic [47:0] known_total);
		energy_beat_t beat;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_intensity <= x;
		pixel_label <= lab;
		end_of_frame <= eof;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (energy_of_pixel(x, lab, eof, beat)) begin
			if (known) beat.total = known_total;
			pending_energy.push_back(beat);
		end
	endtask

	// Waits for every frame total, then idles long enough to cover an
	// end-of-frame sweep of the full line store.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_energy.size() != 0) @(posedge clk);
		repeat (2 * LINE_DEPTH + 40) @(posedge clk);
	endtask

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		energy_beat_t want;
		if (out_valid && !out_stall) begin
			if (pending_energy.size() == 0) begin
				$error("energy beat with no frame outstanding");
				mismatches++;
			end else begin
				want = pending_energy.pop_front();
				if (energy_total !== want.total) begin
					$error("energy_total expected %0d actual %0d", want.total,
						energy_total);
					mismatches++;
				end
				if (energy_saturated !== want.sat) begin
					$error("energy_saturated expected %0d actual %0d", want.sat,
						energy_saturated);
					mismatches++;
				end
			end
		end
	end

	// The watchdog counts cycles in which no beat crosses either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("segmentation_energy_eval verification failed");
			$finish;
		end
	end

	// Directed rows at the reset settings (width 640, thresholds 80 and 50,
	// penalty 2000). A lone pixel has no neighbours, so its total is either
	// zero or the whole penalty in fixed point; the thresholds are strict.
	localparam logic [47:0] PEN_RST = 48'd2000 << 8;
	pixel_row_t directed [15] = '{
		'{8'd255, 1'b0, 1'b1, 1'b1, PEN_RST},
		'{8'd0,   1'b1, 1'b1, 1'b1, PEN_RST},
		'{8'd60,  1'b0, 1'b1, 1'b1, 48'd0},
		'{8'd80,  1'b0, 1'b1, 1'b1, 48'd0},
		'{8'd50,  1'b1, 1'b1, 1'b1, 48'd0},
		'{8'd81,  1'b0, 1'b1, 1'b1, PEN_RST},
		'{8'd49,  1'b1, 1'b1, 1'b1, PEN_RST},
		'{8'd0,   1'b0, 1'b0, 1'b0, 48'd0},
		'{8'd255, 1'b1, 1'b0, 1'b0, 48'd0},
		'{8'd128, 1'b1, 1'b0, 1'b0, 48'd0},
		'{8'd128, 1'b1, 1'b0, 1'b0, 48'd0},
		'{8'd10,  1'b0, 1'b0, 1'b0, 48'd0},
		'{8'd200, 1'b1, 1'b0, 1'b0, 48'd0},
		'{8'd255, 1'b0, 1'b0, 1'b0, 48'd0},
		'{8'd0,   1'b1, 1'b1, 1'b0, 48'd0}
	};

	// Widths per phase: 0 acts as 1, 8191 acts as the full line store.
	int unsigned phase_width [14] = '{1, 2, 3, 4, 7, 16, 33, 0, 8191, 4096, 5, 640, 2, 13};

	initial begin
		int unsigned phase;
		int unsigned w;
		int unsigned frame_len;
		int unsigned phase_items;
		logic [7:0]  x;
		logic        lab;
		logic [31:0] hi_thr;
		logic [31:0] lo_thr;
		logic [31:0] pen;
		bit          paused_once;
		build_cost_tables();
		restart_frame();
		paused_once = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_pixel(directed[i].intensity, directed[i].label, directed[i].eof,
				directed[i].known, directed[i].total);
		wait_until_idle();

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			// Idling pattern: none, sender gaps, receiver stalls, then both.
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 45; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 45; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			// Threshold and penalty extremes come first, random settings later.
			case (phase)
				0: begin hi_thr = 0;   lo_thr = 255; pen = 65535; end
				1: begin hi_thr = 255; lo_thr = 0;   pen = 0;     end
				2: begin hi_thr = 255; lo_thr = 255; pen = 1;     end
				default: begin
					hi_thr = $urandom_range(255);
					lo_thr = $urandom_range(255);
					pen = $urandom_range(65535);
				end
			endcase
			w = phase_width[phase % 14];
			reg_write(sege_pkg::REG_IMAGE_WIDTH, w);
			reg_write(sege_pkg::REG_HIGH_THRESHOLD, hi_thr);
			reg_write(sege_pkg::REG_LOW_THRESHOLD, lo_thr);
			reg_write(sege_pkg::REG_PENALTY, pen);
			if (w == 0) w = 1;
			if (w > LINE_DEPTH) w = LINE_DEPTH;
			phase_items = 0;
			while (phase_items < 130) begin
				// Small widths get whole rows plus often a short last row;
				// wide images get short frames only.
				if (w > 64) frame_len = $urandom_range(1, 40);
				else frame_len = w * $urandom_range(1, 5) +
					(($urandom_range(1) == 1) ? $urandom_range(w - 1) : 0);
				for (int p = 0; p < frame_len; p++) begin
					case ($urandom_range(9))
						0: x = 8'd0;
						1: x = 8'd255;
						default: x = 8'($urandom_range(255));
					endcase
					// Labels mostly agree with the thresholds, with noise.
					if ($urandom_range(9) < 7) lab = (x > hi_thr[7:0]) ? 1'b1 :
						((x < lo_thr[7:0]) ? 1'b0 : 1'($urandom_range(1)));
					else lab = 1'($urandom_range(1));
					send_pixel(x, lab, (p == frame_len - 1), 1'b0, 48'd0);
				end
				phase_items += frame_len;
				// Once, the sender holds off until every total has come back.
				if (!paused_once && phase == 5) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending_energy.size() != 0) @(posedge clk);
					paused_once = 1'b1;
				end
			end
			wait_until_idle();
			phase++;
		end

		if (mismatches == 0 && pending_energy.size() == 0)
			$display("segmentation_energy_eval verification clean");
		else
			$display("segmentation_energy_eval verification failed");
		$finish;
	end
endmodule
